// File: rtl/stt_pkg.sv
package stt_pkg;

   // Results of one stop burst are capped at this many block write bytes
   localparam int MAX_RESULTS = 32;

   // Event queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   // Bus event codes as they arrive on the request channel
   typedef enum logic [2:0] {
      EV_RESTART  = 3'd0,
      EV_START    = 3'd1,
      EV_TX_ABORT = 3'd2,
      EV_STOP     = 3'd3,
      EV_RX_BYTE  = 3'd4,
      EV_RD_REQ   = 3'd5,
      EV_LOAD     = 3'd6
   } ev_type;

   // Result kinds
   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_QUICK    = 3'd1,
      KIND_SEND     = 3'd2,
      KIND_BLOCK    = 3'd3,
      KIND_READ_REQ = 3'd4,
      KIND_UNDO     = 3'd5,
      KIND_TX_BYTE  = 3'd6
   } kind_type;

   // Operations handed from front to back (ignored events never get queued)
   typedef enum logic [2:0] {
      OP_RESTART = 3'd0,
      OP_START   = 3'd1,
      OP_ABORT   = 3'd2,
      OP_STOP    = 3'd3,
      OP_RX      = 3'd4,
      OP_RD_REQ  = 3'd5,
      OP_LOAD    = 3'd6
   } op_type;

   // Back end sequencer
   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_TX    = 2'd1,
      BK_BURST = 2'd2
   } back_state_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] bus_byte;
      logic       arb_lost;
      logic       slave_arb_lost;
      logic [4:0] load_index;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] code_byte;
      logic [7:0] payload_byte;
      logic [4:0] byte_position;
      logic       quick_bit;
      logic       last_of_run;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      op_type     op;
      logic [7:0] data_byte;
      logic [4:0] load_index;
   } op_entry_type;

   // Head of the event queue as seen by the back end
   typedef struct packed {
      logic         valid;
      op_entry_type entry;
   } q_head_type;

endpackage

// File: rtl/stt_front.sv
module stt_front #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  stt_pkg::req_type     req,
   input  logic                 pop,
   output stt_pkg::q_head_type  head
);

   localparam int CNT_W = $clog2(stt_pkg::QUEUE_DEPTH + 1);

   stt_pkg::op_entry_type entry_ff [stt_pkg::QUEUE_DEPTH];
   logic [stt_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [stt_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;

   stt_pkg::op_entry_type cls_entry;
   logic                  cls_keep;
   logic                  push;

   // Classify the incoming event; drop the ones that do nothing
   always_comb begin
      cls_entry.data_byte  = req.bus_byte;
      cls_entry.load_index = req.load_index;
      cls_entry.op         = stt_pkg::OP_RESTART;
      cls_keep             = 1'b1;
      case (stt_pkg::ev_type'(req.cmd))
         stt_pkg::EV_RESTART:  cls_entry.op = stt_pkg::OP_RESTART;
         stt_pkg::EV_START:    cls_entry.op = stt_pkg::OP_START;
         stt_pkg::EV_TX_ABORT: begin
            cls_entry.op = stt_pkg::OP_ABORT;
            cls_keep     = req.arb_lost & req.slave_arb_lost;
         end
         stt_pkg::EV_STOP:     cls_entry.op = stt_pkg::OP_STOP;
         stt_pkg::EV_RX_BYTE:  cls_entry.op = stt_pkg::OP_RX;
         stt_pkg::EV_RD_REQ:   cls_entry.op = stt_pkg::OP_RD_REQ;
         stt_pkg::EV_LOAD: begin
            cls_entry.op = stt_pkg::OP_LOAD;
            cls_keep     = ({2'b00, req.load_index} < 7'(BUFFER_DEPTH));
         end
         default:              cls_keep = 1'b0;
      endcase
   end

   // Queue control
   assign req_ready = (fill_ff < CNT_W'(stt_pkg::QUEUE_DEPTH));
   assign push      = req_valid & req_ready & cls_keep;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!push && pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= cls_entry;
      end
   end

   assign head.valid = (fill_ff != '0);
   assign head.entry = entry_ff[rd_ptr_ff];

endmodule

// File: rtl/stt_back.sv
module stt_back #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  stt_pkg::q_head_type  head,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output stt_pkg::rsp_type     rsp
);

   localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam int CW = $clog2(BUFFER_DEPTH + 1);

   // Transaction state
   stt_pkg::back_state_type state_ff, state_in;
   logic          abort_ff, abort_in;
   logic          cmd_seen_ff, cmd_seen_in;
   logic          restart_ff, restart_in;
   logic [7:0]    code_ff, code_in;
   logic [CW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] len_ff, len_in;

   // Byte buffer; an entry whose valid bit is clear reads as zero
   logic [7:0]              data_mem [BUFFER_DEPTH];
   logic [BUFFER_DEPTH-1:0] valid_bits_ff;
   logic [7:0]              rd_data_ff;
   logic                    rd_hit_ff;

   logic          wr_en, rd_en, clear_txn, emit, out_free, burst_last;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    wr_data, rd_byte;
   logic [CW-1:0] idx_next;
   logic [6:0]    count_wide, idx_wide, li_wide;
   stt_pkg::rsp_type res;
   stt_pkg::rsp_type rsp_ff;
   logic             rsp_valid_ff;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign count_wide = 7'(count_ff);
   assign idx_wide   = 7'(idx_ff);
   assign li_wide    = 7'(head.entry.load_index);
   assign idx_next   = idx_ff + 1'b1;
   assign burst_last = (idx_next == len_ff);
   assign rd_byte    = rd_hit_ff ? rd_data_ff : 8'h00;

   // Sequencer: one op, tx byte or burst byte per cycle while output is free
   always_comb begin
      state_in    = state_ff;
      abort_in    = abort_ff;
      cmd_seen_in = cmd_seen_ff;
      restart_in  = restart_ff;
      code_in     = code_ff;
      count_in    = count_ff;
      ovf_in      = ovf_ff;
      idx_in      = idx_ff;
      len_in      = len_ff;
      pop         = 1'b0;
      wr_en       = 1'b0;
      wr_addr     = AW'(count_ff);
      wr_data     = head.entry.data_byte;
      rd_en       = 1'b0;
      rd_addr     = AW'(count_ff);
      clear_txn   = 1'b0;
      emit        = 1'b0;
      res         = '0;
      res.code_byte   = code_ff;
      res.last_of_run = 1'b1;

      case (state_ff)
         stt_pkg::BK_IDLE: begin
            if (head.valid && out_free) begin
               pop = 1'b1;
               case (head.entry.op)
                  stt_pkg::OP_RESTART: restart_in = 1'b1;
                  stt_pkg::OP_START: begin
                     if (restart_ff) begin
                        emit     = 1'b1;
                        res.kind = stt_pkg::KIND_READ_REQ;
                     end
                  end
                  stt_pkg::OP_ABORT: begin
                     abort_in    = 1'b1;
                     cmd_seen_in = 1'b0;
                     emit        = 1'b1;
                     res.kind    = stt_pkg::KIND_UNDO;
                  end
                  stt_pkg::OP_STOP: begin
                     if (!cmd_seen_ff) begin
                        emit          = 1'b1;
                        res.kind      = stt_pkg::KIND_QUICK;
                        res.quick_bit = abort_ff;
                        res.overflow  = ovf_ff;
                        clear_txn     = 1'b1;
                     end else if (count_ff == '0) begin
                        emit         = 1'b1;
                        res.kind     = stt_pkg::KIND_SEND;
                        res.overflow = ovf_ff;
                        clear_txn    = 1'b1;
                     end else begin
                        // walk the stored bytes from entry 0
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        len_in   = (count_wide > 7'(stt_pkg::MAX_RESULTS)) ?
                                   CW'(stt_pkg::MAX_RESULTS) : count_ff;
                        state_in = stt_pkg::BK_BURST;
                     end
                  end
                  stt_pkg::OP_RX: begin
                     if (cmd_seen_ff) begin
                        if (count_ff < CW'(BUFFER_DEPTH)) begin
                           wr_en    = 1'b1;
                           count_in = count_ff + 1'b1;
                        end else begin
                           ovf_in = 1'b1;
                        end
                     end else begin
                        code_in     = head.entry.data_byte;
                        cmd_seen_in = 1'b1;
                     end
                  end
                  stt_pkg::OP_RD_REQ: begin
                     if (cmd_seen_ff) begin
                        if (count_ff < CW'(BUFFER_DEPTH)) begin
                           rd_en    = 1'b1;
                           state_in = stt_pkg::BK_TX;
                        end else begin
                           // past the buffer: send zero
                           ovf_in            = 1'b1;
                           emit              = 1'b1;
                           res.kind          = stt_pkg::KIND_TX_BYTE;
                           res.byte_position = count_wide[4:0];
                           res.overflow      = 1'b1;
                        end
                     end else begin
                        code_in          = head.entry.data_byte;
                        cmd_seen_in      = 1'b1;
                        emit             = 1'b1;
                        res.kind         = stt_pkg::KIND_TX_BYTE;
                        res.code_byte    = head.entry.data_byte;
                        res.payload_byte = head.entry.data_byte;
                     end
                  end
                  stt_pkg::OP_LOAD: begin
                     wr_en   = 1'b1;
                     wr_addr = AW'(li_wide);
                  end
                  default: ;
               endcase
            end
         end
         stt_pkg::BK_TX: begin
            if (out_free) begin
               emit              = 1'b1;
               res.kind          = stt_pkg::KIND_TX_BYTE;
               res.payload_byte  = rd_byte;
               res.byte_position = count_wide[4:0];
               count_in          = count_ff + 1'b1;
               state_in          = stt_pkg::BK_IDLE;
            end
         end
         stt_pkg::BK_BURST: begin
            if (out_free) begin
               emit              = 1'b1;
               res.kind          = stt_pkg::KIND_BLOCK;
               res.payload_byte  = rd_byte;
               res.byte_position = idx_wide[4:0];
               res.last_of_run   = burst_last;
               res.overflow      = ovf_ff;
               if (burst_last) begin
                  clear_txn = 1'b1;
                  state_in  = stt_pkg::BK_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = AW'(idx_next);
                  idx_in  = idx_next;
               end
            end
         end
         default: state_in = stt_pkg::BK_IDLE;
      endcase

      // stop ends the transaction
      if (clear_txn) begin
         abort_in    = 1'b0;
         cmd_seen_in = 1'b0;
         restart_in  = 1'b0;
         code_in     = 8'h00;
         count_in    = '0;
         ovf_in      = 1'b0;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= stt_pkg::BK_IDLE;
         abort_ff     <= 1'b0;
         cmd_seen_ff  <= 1'b0;
         restart_ff   <= 1'b0;
         code_ff      <= 8'h00;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         len_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         abort_ff    <= abort_in;
         cmd_seen_ff <= cmd_seen_in;
         restart_ff  <= restart_in;
         code_ff     <= code_in;
         count_ff    <= count_in;
         ovf_ff      <= ovf_in;
         idx_ff      <= idx_in;
         len_ff      <= len_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_ff <= res;
      end
   end

   // Entry valid bits, all dropped at reset and at stop
   always_ff @(posedge clock) begin
      if (reset || clear_txn) begin
         valid_bits_ff <= '0;
      end else if (wr_en) begin
         valid_bits_ff[wr_addr] <= 1'b1;
      end
   end

   // Buffer memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         data_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= data_mem[rd_addr];
         rd_hit_ff  <= valid_bits_ff[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// File: rtl/smbus_target_transaction_tracker.sv
// SMBus target transaction tracker. Each request beat is one bus event
// (restart, start, tx abort, stop, rx byte, read request, buffer load); each
// response beat is one result, and last_of_run flags the final result of an
// event. The front end takes one event per cycle into a two-entry queue
// while it has room, and drops events that have no effect. The back end
// retires one event per cycle while its output is free; a read request that
// fetches from the byte buffer goes through a transmit state, and a stop
// sends its stored bytes (capped at 32) one per cycle, paced by the buffer's
// single registered read port. A result waiting in the output register
// stalls only the back end; the queue keeps taking events until it is full.
module smbus_target_transaction_tracker #(
   parameter int BUFFER_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  stt_pkg::req_type req,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output stt_pkg::rsp_type rsp
);

   stt_pkg::q_head_type q_head;
   logic                q_pop;

   stt_front #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .pop       (q_pop),
      .head      (q_head)
   );

   stt_back #(
      .BUFFER_DEPTH(BUFFER_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (q_head),
      .pop       (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

`ifndef SYNTHESIS
   // back end never pops an empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_head.valid)
      else $error("pop from empty event queue");

   // a presented result always has a real kind
   a_kind_real: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.kind != stt_pkg::KIND_NONE))
      else $error("result with kind none");

   // only block write bytes may come without the last marker
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp.kind != stt_pkg::KIND_BLOCK)) |-> rsp.last_of_run)
      else $error("single result without last marker");
`endif

endmodule
